// ----- rtl/core/tlfid_pkg.sv -----
package tlfid_pkg;

  // request and response field widths
  localparam int COMMAND_W   = 2;
  localparam int SUBJECT_W   = 4;
  localparam int KEY_FIELD_W = 5;
  localparam int STATUS_W    = 3;

  // subjects reachable through the subject field
  localparam int SUBJECT_SPAN = 1 << SUBJECT_W;

  // default sizes
  localparam int SUBJECT_COUNT_DEF = 16;
  localparam int MAJOR_KEYS_DEF    = 16;
  localparam int MINOR_KEYS_DEF    = 16;

  // configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int NO_ALLOC_W  = 16;
  localparam logic REG_NO_ALLOC = 1'b0;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_FILL   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_SUBJECT = 3'd1,
    ST_FORBIDDEN   = 3'd2,
    ST_NO_MAJOR    = 3'd3,
    ST_NO_MINOR    = 3'd4,
    ST_DUPLICATE   = 3'd5
  } status_t;

endpackage

// ----- rtl/core/tlfid_ifs.sv -----
interface tlfid_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [tlfid_pkg::COMMAND_W-1:0]      command;
  logic [tlfid_pkg::SUBJECT_W-1:0]      subject_id;
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    major_key;
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    minor_key;

  modport source (output valid, command, subject_id, major_key, minor_key, input ready);
  modport sink (input valid, command, subject_id, major_key, minor_key, output ready);
endinterface

interface tlfid_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    major_out;
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    minor_out;
  logic [tlfid_pkg::STATUS_W-1:0]       status;

  modport source (output valid, major_out, minor_out, status, input ready);
  modport sink (input valid, major_out, minor_out, status, output ready);
endinterface

// ----- rtl/core/two_level_lowest_free_id_allocator.sv -----
// sequencing: an accepted request enters the major map state, and goes on to a read state and a
//   minor map state (which writes for add or remove) only when the major map alone cannot settle it;
//   a done state then registers the response once the output is free, and the block takes no new
//   request until then, with the single lowest-free encoder serving both levels in turn
// reset (rst, synchronous): clears the no-alloc mask, major maps and response valid, then a pass
//   zeroes the minor map row by row over min(SUBJECT_COUNT, 16) * MAJOR_KEYS rows (256 at defaults)
module two_level_lowest_free_id_allocator #(
  parameter int SUBJECT_COUNT = tlfid_pkg::SUBJECT_COUNT_DEF,
  parameter int MAJOR_KEYS    = tlfid_pkg::MAJOR_KEYS_DEF,
  parameter int MINOR_KEYS    = tlfid_pkg::MINOR_KEYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tlfid_req_if.sink                      req,
  tlfid_rsp_if.source                    rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlfid_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlfid_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlfid_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  // only subjects below the field span can ever be addressed
  localparam int SUBJ_N    = (SUBJECT_COUNT < tlfid_pkg::SUBJECT_SPAN) ?
                             SUBJECT_COUNT : tlfid_pkg::SUBJECT_SPAN;
  localparam int SUBJ_W    = $clog2(SUBJ_N);
  localparam int MEM_DEPTH = SUBJ_N * MAJOR_KEYS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int UNIT_W    = (MAJOR_KEYS > MINOR_KEYS) ? MAJOR_KEYS : MINOR_KEYS;
  localparam int KEY_W     = $clog2(UNIT_W + 1);
  localparam int MAJ_W     = ($clog2(MAJOR_KEYS + 1) > tlfid_pkg::KEY_FIELD_W) ?
                             $clog2(MAJOR_KEYS + 1) : tlfid_pkg::KEY_FIELD_W;
  localparam int MIN_W     = ($clog2(MINOR_KEYS + 1) > tlfid_pkg::KEY_FIELD_W) ?
                             $clog2(MINOR_KEYS + 1) : tlfid_pkg::KEY_FIELD_W;
  localparam int CMP_W     = ($clog2(SUBJECT_COUNT + 1) > tlfid_pkg::SUBJECT_W) ?
                             $clog2(SUBJECT_COUNT + 1) : tlfid_pkg::SUBJECT_W;

  localparam logic [UNIT_W-1:0] MAJ_MASK  = UNIT_W'({MAJOR_KEYS{1'b1}});
  localparam logic [UNIT_W-1:0] MIN_MASK  = UNIT_W'({MINOR_KEYS{1'b1}});
  localparam logic [MAJ_W-1:0]  MAJ_LIMIT = MAJ_W'(MAJOR_KEYS);
  localparam logic [MIN_W-1:0]  MIN_LIMIT = MIN_W'(MINOR_KEYS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [CMP_W-1:0]  SUBJ_LIMIT = CMP_W'(SUBJECT_COUNT);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_MAJ   = 6'b000100,
    S_RD    = 6'b001000,
    S_MIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // control registers
  logic [ADDR_W-1:0]                    clr_addr;
  logic [tlfid_pkg::NO_ALLOC_W-1:0]     no_alloc_mask;
  logic [MAJOR_KEYS-1:0]                major_map [SUBJ_N];
  logic                                 rsp_valid;

  // request working registers
  logic [tlfid_pkg::COMMAND_W-1:0]      cmd_r;
  logic [tlfid_pkg::SUBJECT_W-1:0]      subj_r;
  logic [MAJ_W-1:0]                     maj_r;
  logic [MIN_W-1:0]                     min_r;
  logic [tlfid_pkg::STATUS_W-1:0]       status_r;

  logic [MAJ_W-1:0]                     maj_next;
  logic [MIN_W-1:0]                     min_next;
  logic [tlfid_pkg::STATUS_W-1:0]       status_next;

  // response register
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    major_out_r;
  logic [tlfid_pkg::KEY_FIELD_W-1:0]    minor_out_r;
  logic [tlfid_pkg::STATUS_W-1:0]       status_out_r;

  // minor map memory, one row per subject and major key
  logic [MINOR_KEYS-1:0]                minor_mem [MEM_DEPTH];
  logic [MINOR_KEYS-1:0]                mem_rdata;
  logic [ADDR_W-1:0]                    mem_addr;
  logic                                 mem_we;
  logic [ADDR_W-1:0]                    mem_waddr;
  logic [MINOR_KEYS-1:0]                mem_wdata;

  // decode helpers
  logic                                 bad_subj;
  logic                                 forbid;
  logic                                 keys_in_range;
  logic [MAJOR_KEYS-1:0]                major_row;
  logic [MAJOR_KEYS-1:0]                jbit;
  logic [MINOR_KEYS-1:0]                nbit;
  logic                                 dup;
  logic                                 major_we;
  logic [MAJOR_KEYS-1:0]                major_wdata;
  logic                                 cfg_write;
  logic                                 out_free;

  // shared lowest-free encoder
  logic [UNIT_W-1:0]                    unit_map;
  logic [UNIT_W-1:0]                    unit_mask;
  logic [UNIT_W-1:0]                    unit_free;
  logic [UNIT_W-1:0]                    unit_low;
  logic [KEY_W-1:0]                     unit_idx;
  logic [KEY_W-1:0]                     unit_key;
  logic                                 unit_found;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == tlfid_pkg::REG_NO_ALLOC) ?
                     tlfid_pkg::PDATA_W'(no_alloc_mask) : '0;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.major_out = major_out_r;
  assign rsp.minor_out = minor_out_r;
  assign rsp.status    = status_out_r;
  assign out_free      = !rsp_valid || rsp.ready;

  // subject zero and subjects at or above the configured count are rejected
  assign bad_subj = (subj_r == '0) || (CMP_W'(subj_r) >= SUBJ_LIMIT);
  assign forbid   = no_alloc_mask[subj_r];
  assign keys_in_range = (maj_r != '0) && (maj_r <= MAJ_LIMIT) &&
                         (min_r != '0) && (min_r <= MIN_LIMIT);

  assign major_row = major_map[subj_r[SUBJ_W-1:0]];
  assign jbit      = MAJOR_KEYS'(1) << MAJ_W'(maj_r - MAJ_W'(1));
  assign nbit      = MINOR_KEYS'(1) << MIN_W'(min_r - MIN_W'(1));
  assign dup       = |(mem_rdata & nbit);
  assign mem_addr  = ADDR_W'(ADDR_W'(subj_r) * ADDR_W'(MAJOR_KEYS)) +
                     ADDR_W'(maj_r - MAJ_W'(1));

  // encoder input: major map row first, minor map row later
  always_comb begin
    if (state == S_MAJ) begin
      unit_map  = UNIT_W'(major_row);
      unit_mask = MAJ_MASK;
    end else begin
      unit_map  = UNIT_W'(mem_rdata);
      unit_mask = MIN_MASK;
    end
  end

  // isolate the lowest clear bit, then encode its position
  always_comb begin
    unit_free  = ~unit_map & unit_mask;
    unit_low   = unit_free & (~unit_free + UNIT_W'(1));
    unit_found = |unit_free;
    unit_idx   = '0;
    for (int i = 0; i < UNIT_W; i++) begin
      if (unit_low[i]) begin
        unit_idx = unit_idx | KEY_W'(i);
      end
    end
    unit_key = unit_idx + KEY_W'(1);
  end

  // sequencer and datapath decisions
  always_comb begin
    state_next  = state;
    maj_next    = maj_r;
    min_next    = min_r;
    status_next = status_r;
    major_we    = 1'b0;
    major_wdata = major_row;
    mem_we      = 1'b0;
    mem_waddr   = mem_addr;
    mem_wdata   = mem_rdata;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_MAJ;
        end
      end
      S_CLEAR: begin
        // zero one minor map row a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_MAJ: begin
        status_next = tlfid_pkg::ST_OK;
        state_next  = S_DONE;
        if (bad_subj && (cmd_r == tlfid_pkg::CMD_FILL || cmd_r == tlfid_pkg::CMD_ADD ||
                         cmd_r == tlfid_pkg::CMD_REMOVE)) begin
          status_next = tlfid_pkg::ST_BAD_SUBJECT;
        end else if (cmd_r == tlfid_pkg::CMD_FILL) begin
          if (maj_r == '0 && forbid) begin
            status_next = tlfid_pkg::ST_FORBIDDEN;
          end else if (maj_r == '0 && !unit_found) begin
            status_next = tlfid_pkg::ST_NO_MAJOR;
          end else begin
            if (maj_r == '0) begin
              maj_next = MAJ_W'(unit_key);
            end
            if (min_r != '0) begin
              state_next = S_DONE;
            end else if (forbid) begin
              status_next = tlfid_pkg::ST_FORBIDDEN;
            end else if (maj_r > MAJ_LIMIT) begin
              // a major key past the table has no minor map: all minors free
              min_next = MIN_W'(1);
            end else begin
              state_next = S_RD;
            end
          end
        end else if (cmd_r == tlfid_pkg::CMD_ADD || cmd_r == tlfid_pkg::CMD_REMOVE) begin
          // out-of-range keys are ignored with status ok
          if (keys_in_range) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_MIN;
      end
      S_MIN: begin
        state_next = S_DONE;
        if (cmd_r == tlfid_pkg::CMD_FILL) begin
          if (unit_found) begin
            min_next = MIN_W'(unit_key);
          end else begin
            status_next = tlfid_pkg::ST_NO_MINOR;
          end
        end else if (cmd_r == tlfid_pkg::CMD_ADD) begin
          if (dup) begin
            status_next = tlfid_pkg::ST_DUPLICATE;
          end else begin
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata | nbit;
            major_we    = 1'b1;
            major_wdata = major_row | jbit;
          end
        end else begin
          // remove clears the major bit even when other minors remain
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata & ~nbit;
          major_we    = 1'b1;
          major_wdata = major_row & ~jbit;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      no_alloc_mask <= '0;
      rsp_valid     <= 1'b0;
      for (int s = 0; s < SUBJ_N; s++) begin
        major_map[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cfg_write && paddr[2] == tlfid_pkg::REG_NO_ALLOC) begin
        no_alloc_mask <= pwdata[tlfid_pkg::NO_ALLOC_W-1:0];
      end
      if (major_we) begin
        major_map[subj_r[SUBJ_W-1:0]] <= major_wdata;
      end
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request working registers and response payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd_r  <= req.command;
      subj_r <= req.subject_id;
      maj_r  <= MAJ_W'(req.major_key);
      min_r  <= MIN_W'(req.minor_key);
    end else begin
      maj_r <= maj_next;
      min_r <= min_next;
    end
    status_r <= status_next;
    if (state == S_DONE && out_free) begin
      major_out_r  <= maj_r[tlfid_pkg::KEY_FIELD_W-1:0];
      minor_out_r  <= min_r[tlfid_pkg::KEY_FIELD_W-1:0];
      status_out_r <= status_r;
    end
  end

  // minor map memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      minor_mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_RD) begin
      mem_rdata <= minor_mem[mem_addr];
    end
  end

`ifndef SYNTH
  // an accepted request always starts at the major map
  a_accept_to_maj: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_MAJ))
    else $error("accepted request did not enter major lookup");

  // leaving reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (state == S_CLEAR))
    else $error("clearing pass skipped after reset");

  // fill never writes the maps
  a_fill_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIN && (mem_we || major_we)) |->
      (cmd_r == tlfid_pkg::CMD_ADD || cmd_r == tlfid_pkg::CMD_REMOVE))
    else $error("map written outside add or remove");

  // a duplicate status only comes from add
  a_dup_from_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && status_r == tlfid_pkg::ST_DUPLICATE) |-> (cmd_r == tlfid_pkg::CMD_ADD))
    else $error("duplicate status outside add");

  // a successful fill reports both keys nonzero
  a_fill_keys_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cmd_r == tlfid_pkg::CMD_FILL && status_r == tlfid_pkg::ST_OK) |->
      (maj_r != '0 && min_r != '0))
    else $error("fill reported ok with a zero key");
`endif

endmodule

// ----- tb/tb_two_level_lowest_free_id_allocator.sv -----
module tb_two_level_lowest_free_id_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUBJECT_COUNT = tlfid_pkg::SUBJECT_COUNT_DEF;
  localparam int MAJOR_KEYS    = tlfid_pkg::MAJOR_KEYS_DEF;
  localparam int MINOR_KEYS    = tlfid_pkg::MINOR_KEYS_DEF;

  localparam int COMMAND_W   = tlfid_pkg::COMMAND_W;
  localparam int SUBJECT_W   = tlfid_pkg::SUBJECT_W;
  localparam int KEY_FIELD_W = tlfid_pkg::KEY_FIELD_W;
  localparam int PADDR_W     = tlfid_pkg::PADDR_W;
  localparam int PDATA_W     = tlfid_pkg::PDATA_W;
  localparam int NO_ALLOC_W  = tlfid_pkg::NO_ALLOC_W;

  // command value 3 has no enum member: the block echoes the keys
  localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [PADDR_W-1:0] NO_ALLOC_ADDR = PADDR_W'(4 * tlfid_pkg::REG_NO_ALLOC);

  // cycles after the last response before the block counts as idle
  localparam int SETTLE_CYCLES = 8;
  // reset clearing pass covers 256 minor map rows, so this stays well above it
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] major;
    logic [KEY_FIELD_W-1:0] minor;
    tlfid_pkg::status_t     status;
  } id_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tlfid_req_if req_ch ();
  tlfid_rsp_if rsp_ch ();

  two_level_lowest_free_id_allocator uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the block's state
  logic [MAJOR_KEYS-1:0] major_used [SUBJECT_COUNT];
  logic [MINOR_KEYS-1:0] minor_used [SUBJECT_COUNT*MAJOR_KEYS];
  logic [NO_ALLOC_W-1:0] no_alloc_mask;

  // responses still owed by the block, oldest first
  id_result_t awaited_ids [$];
  id_result_t want_id;

  int  err_count;
  int  quiet_cycles = 0;
  // when set, neither side inserts idle cycles
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // lowest key k in 1..count with bit k-1 clear, 0 when all are taken
  function automatic logic [KEY_FIELD_W-1:0] lowest_clear_key(logic [63:0] map, int count);
    for (int k = 0; k < count; k++) begin
      if (!map[k]) return KEY_FIELD_W'(k + 1);
    end
    return '0;
  endfunction

  // computes the response to one request and updates the tracked ids
  function automatic id_result_t apply_id_command(logic [COMMAND_W-1:0] cmd,
                                                  logic [SUBJECT_W-1:0] subj,
                                                  logic [KEY_FIELD_W-1:0] maj,
                                                  logic [KEY_FIELD_W-1:0] mnr);
    id_result_t res;
    int slot;
    logic [MINOR_KEYS-1:0] pair_map;
    logic blocked;
    res.status = tlfid_pkg::ST_OK;
    slot = 0;
    pair_map = '0;
    blocked = no_alloc_mask[subj];
    if (cmd != CMD_UNUSED && (subj == 0 || int'(subj) >= SUBJECT_COUNT)) begin
      // bad subject: echo the keys, touch nothing
      res.status = tlfid_pkg::ST_BAD_SUBJECT;
    end else if (cmd == tlfid_pkg::CMD_FILL) begin
      if (maj == 0) begin
        if (blocked) begin
          res.status = tlfid_pkg::ST_FORBIDDEN;
        end else begin
          maj = lowest_clear_key(major_used[subj], MAJOR_KEYS);
          if (maj == 0) res.status = tlfid_pkg::ST_NO_MAJOR;
        end
      end
      if (res.status == tlfid_pkg::ST_OK && mnr == 0) begin
        if (blocked) begin
          res.status = tlfid_pkg::ST_FORBIDDEN;
        end else begin
          // a major key beyond the table has no used minors
          if (maj <= MAJOR_KEYS) pair_map = minor_used[subj*MAJOR_KEYS + maj - 1];
          mnr = lowest_clear_key(pair_map, MINOR_KEYS);
          if (mnr == 0) res.status = tlfid_pkg::ST_NO_MINOR;
        end
      end
    end else if (cmd == tlfid_pkg::CMD_ADD || cmd == tlfid_pkg::CMD_REMOVE) begin
      // out of range keys are silently ignored
      if (maj >= 1 && maj <= MAJOR_KEYS && mnr >= 1 && mnr <= MINOR_KEYS) begin
        slot = subj*MAJOR_KEYS + maj - 1;
        if (cmd == tlfid_pkg::CMD_ADD) begin
          if (minor_used[slot][mnr-1]) begin
            res.status = tlfid_pkg::ST_DUPLICATE;
          end else begin
            major_used[subj][maj-1] = 1'b1;
            minor_used[slot][mnr-1] = 1'b1;
          end
        end else begin
          // remove drops the major bit even with other minors left under it
          major_used[subj][maj-1] = 1'b0;
          minor_used[slot][mnr-1] = 1'b0;
        end
      end
    end
    res.major = maj;
    res.minor = mnr;
    return res;
  endfunction

  // offers one request, with random idle cycles ahead of it unless steady is set, and
  // records the predicted response at the edge that accepts it
  task automatic send_request(logic [COMMAND_W-1:0] cmd, logic [SUBJECT_W-1:0] subj,
                              logic [KEY_FIELD_W-1:0] maj, logic [KEY_FIELD_W-1:0] mnr);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 32) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.command    = cmd;
    req_ch.subject_id = subj;
    req_ch.major_key  = maj;
    req_ch.minor_key  = mnr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_ids.push_back(apply_id_command(cmd, subj, maj, mnr));
  endtask

  // stops offering requests and waits until the block has gone quiet
  task automatic drain_requests();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (awaited_ids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes the no-alloc mask over the config port, then reads it back
  task automatic write_no_alloc_mask(logic [NO_ALLOC_W-1:0] value);
    drain_requests();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = NO_ALLOC_ADDR;
    pwdata  = PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    no_alloc_mask = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[NO_ALLOC_W-1:0] !== value) begin
      $error("no_alloc_subject_mask readback expected %0h got %0h", value,
             prdata[NO_ALLOC_W-1:0]);
      err_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // subject 0 is rejected by every command except the unused one
  task automatic test_invalid_subject();
    send_request(tlfid_pkg::CMD_FILL, 4'd0, 5'd0, 5'd0);
    send_request(tlfid_pkg::CMD_ADD, 4'd0, 5'd5, 5'd5);
    send_request(tlfid_pkg::CMD_REMOVE, 4'd0, 5'd31, 5'd31);
    send_request(CMD_UNUSED, 4'd0, 5'd0, 5'd0);
    send_request(CMD_UNUSED, 4'd7, 5'd31, 5'd31);
  endtask

  // fill on empty maps, given keys echoed, major beyond the table
  task automatic test_fill_and_echo();
    send_request(tlfid_pkg::CMD_FILL, 4'd1, 5'd0, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd1, 5'd16, 5'd16);
    send_request(tlfid_pkg::CMD_FILL, 4'd1, 5'd31, 5'd31);
    send_request(tlfid_pkg::CMD_FILL, 4'd1, 5'd20, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd15, 5'd0, 5'd7);
  endtask

  // add, duplicate add, remove with minors left, ignored key ranges
  task automatic test_add_remove();
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd3, 5'd4);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd3, 5'd4);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd3, 5'd5);
    send_request(tlfid_pkg::CMD_FILL, 4'd2, 5'd3, 5'd0);
    send_request(tlfid_pkg::CMD_REMOVE, 4'd2, 5'd3, 5'd4);
    send_request(tlfid_pkg::CMD_REMOVE, 4'd2, 5'd3, 5'd4);
    send_request(tlfid_pkg::CMD_FILL, 4'd2, 5'd3, 5'd0);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd0, 5'd4);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd17, 5'd4);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd3, 5'd31);
    send_request(tlfid_pkg::CMD_REMOVE, 4'd2, 5'd16, 5'd16);
    send_request(tlfid_pkg::CMD_ADD, 4'd2, 5'd16, 5'd16);
    send_request(tlfid_pkg::CMD_FILL, 4'd2, 5'd16, 5'd0);
  endtask

  // run one subject out of majors and one pair out of minors
  task automatic test_exhaustion();
    for (int m = 1; m <= MAJOR_KEYS; m++) begin
      send_request(tlfid_pkg::CMD_ADD, 4'd5, KEY_FIELD_W'(m), 5'd1);
    end
    send_request(tlfid_pkg::CMD_FILL, 4'd5, 5'd0, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd5, 5'd0, 5'd3);
    for (int n = 2; n <= MINOR_KEYS; n++) begin
      send_request(tlfid_pkg::CMD_ADD, 4'd5, 5'd1, KEY_FIELD_W'(n));
    end
    send_request(tlfid_pkg::CMD_FILL, 4'd5, 5'd1, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd5, 5'd20, 5'd0);
    send_request(tlfid_pkg::CMD_REMOVE, 4'd5, 5'd1, 5'd16);
    send_request(tlfid_pkg::CMD_FILL, 4'd5, 5'd0, 5'd0);
  endtask

  // forbidden subjects refuse allocation at either level but still track keys
  task automatic test_forbidden_mask();
    write_no_alloc_mask(16'h0008);
    send_request(tlfid_pkg::CMD_FILL, 4'd3, 5'd0, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd3, 5'd2, 5'd0);
    send_request(tlfid_pkg::CMD_FILL, 4'd3, 5'd2, 5'd2);
    send_request(tlfid_pkg::CMD_ADD, 4'd3, 5'd2, 5'd2);
    send_request(tlfid_pkg::CMD_FILL, 4'd4, 5'd0, 5'd0);
    write_no_alloc_mask(16'hFFFF);
    send_request(tlfid_pkg::CMD_FILL, 4'd9, 5'd0, 5'd5);
    send_request(tlfid_pkg::CMD_FILL, 4'd0, 5'd0, 5'd0);
    write_no_alloc_mask(16'h0000);
    send_request(tlfid_pkg::CMD_FILL, 4'd3, 5'd0, 5'd0);
  endtask

  // random traffic over phases of differing mask and key spread; narrow
  // phases with heavy adds push subjects and pairs into exhaustion
  task automatic test_random_traffic();
    int shape;
    int subj_hi;
    int major_hi;
    int minor_hi;
    bit heavy_add;
    int roll;
    logic [COMMAND_W-1:0] cmd;
    logic [SUBJECT_W-1:0] subj;
    logic [KEY_FIELD_W-1:0] keys [2];
    int key_hi;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_no_alloc_mask(16'h0000);
        1: write_no_alloc_mask(16'hFFFF);
        RANDOM_PHASES-1: write_no_alloc_mask(16'h0000);
        default: write_no_alloc_mask(NO_ALLOC_W'($urandom_range(0, 16'hFFFF)));
      endcase
      steady = (p == 5);
      shape = p % 4;
      case (shape)
        0: begin
          subj_hi = 15; major_hi = 16; minor_hi = 16;
        end
        1: begin
          subj_hi = 3; major_hi = 3; minor_hi = 3;
        end
        2: begin
          subj_hi = 2; major_hi = 16; minor_hi = 2;
        end
        default: begin
          subj_hi = 2; major_hi = 2; minor_hi = 16;
        end
      endcase
      heavy_add = (shape >= 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (heavy_add) begin
          if (roll < 25) cmd = tlfid_pkg::CMD_FILL;
          else if (roll < 85) cmd = tlfid_pkg::CMD_ADD;
          else if (roll < 95) cmd = tlfid_pkg::CMD_REMOVE;
          else cmd = CMD_UNUSED;
        end else begin
          if (roll < 35) cmd = tlfid_pkg::CMD_FILL;
          else if (roll < 70) cmd = tlfid_pkg::CMD_ADD;
          else if (roll < 95) cmd = tlfid_pkg::CMD_REMOVE;
          else cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 99) < 5) subj = '0;
        else subj = SUBJECT_W'($urandom_range(1, subj_hi));
        for (int f = 0; f < 2; f++) begin
          key_hi = (f == 0) ? major_hi : minor_hi;
          roll = $urandom_range(0, 99);
          // fill asks for each key to be allocated half the time
          if (roll < ((cmd == tlfid_pkg::CMD_FILL) ? 50 : 8)) keys[f] = '0;
          else if (roll < ((cmd == tlfid_pkg::CMD_FILL) ? 55 : 14))
            keys[f] = KEY_FIELD_W'($urandom_range(17, 31));
          else keys[f] = KEY_FIELD_W'($urandom_range(1, key_hi));
        end
        send_request(cmd, subj, keys[0], keys[1]);
      end
    end
    steady = 1'b0;
  endtask

  // response side stalls at random, except during the steady phase
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = steady || ($urandom_range(0, 99) >= 32);
    end
  end

  // compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_ids.size() == 0) begin
        $error("unexpected response: major_out %0d minor_out %0d status %0d",
               rsp_ch.major_out, rsp_ch.minor_out, rsp_ch.status);
        err_count++;
      end else begin
        want_id = awaited_ids.pop_front();
        if (rsp_ch.major_out !== want_id.major) begin
          $error("major_out expected %0d got %0d", want_id.major, rsp_ch.major_out);
          err_count++;
        end
        if (rsp_ch.minor_out !== want_id.minor) begin
          $error("minor_out expected %0d got %0d", want_id.minor, rsp_ch.minor_out);
          err_count++;
        end
        if (rsp_ch.status !== want_id.status) begin
          $error("status expected %0d got %0d", want_id.status, rsp_ch.status);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** two_level_lowest_free_id_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.command    = '0;
    req_ch.subject_id = '0;
    req_ch.major_key  = '0;
    req_ch.minor_key  = '0;
    steady            = 1'b0;
    err_count         = 0;
    no_alloc_mask     = '0;
    foreach (major_used[s]) major_used[s] = '0;
    foreach (minor_used[s]) minor_used[s] = '0;

    // single reset at the start; the block then clears its minor maps
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_invalid_subject();
    test_fill_and_echo();
    test_add_remove();
    test_exhaustion();
    test_forbidden_mask();
    test_random_traffic();

    drain_requests();
    if (err_count == 0) begin
      $display("** two_level_lowest_free_id_allocator: PASSED **");
    end else begin
      $display("** two_level_lowest_free_id_allocator: FAILED **");
    end
    $finish;
  end

endmodule
